// File: hw/rtl/size_class_superblock_allocator_assert.svh
// ---------------------------------------------------------------------------
// allocator assertion macros
// concurrent property wrappers shared by the allocator top level
// ---------------------------------------------------------------------------
`ifndef SIZE_CLASS_SUPERBLOCK_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_SUPERBLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SCA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// next-cycle implication
`define SCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

// File: hw/rtl/sca_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sca_pkg
// constants, types and helper functions of the size class allocator
// ---------------------------------------------------------------------------
package sca_pkg;

    localparam int PAGE_COUNT  = 64;
    localparam int PAGE_BYTES  = 4096;
    localparam int CLASS_COUNT = 7;
    localparam int MIN_SHIFT   = 5;
    localparam int MAX_REQUEST = 2048;
    localparam int OBJ_SLOTS   = PAGE_BYTES >> MIN_SHIFT;
    localparam int SLOT_W      = $clog2(OBJ_SLOTS);
    localparam int PI          = $clog2(PAGE_COUNT);
    localparam int PW          = $clog2(PAGE_COUNT + 1);
    localparam int KW          = (PW > SLOT_W ? PW : SLOT_W) + 1;
    localparam int ONF_W       = PI + SLOT_W;
    localparam int ONF_DEPTH   = PAGE_COUNT * OBJ_SLOTS;
    localparam logic [PW-1:0] NO_PAGE = PW'(PAGE_COUNT);

    typedef enum logic [1:0] {
        ST_OK,
        ST_SIZE,
        ST_NO_PAGE,
        ST_BAD_FREE
    } t_status;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LATCH,
        OP_RESULT,
        OP_SCAN_START,
        OP_SCAN_NEXT,
        OP_INIT,
        OP_FILL,
        OP_WALK_START,
        OP_READ_P,
        OP_WALK_NEXT,
        OP_TAKE,
        OP_TAKE_DONE,
        OP_FREE_READ,
        OP_FREE_SETUP,
        OP_DUP_READ,
        OP_DUP_NEXT,
        OP_PUSH,
        OP_REL_START,
        OP_REL_NEXT,
        OP_RELEASE,
        OP_OUT_LOAD
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_INIT,
        S_FILL,
        S_WREAD,
        S_WCHK,
        S_TAKE_DONE,
        S_FCLS,
        S_DUP,
        S_DUP2,
        S_RCHK,
        S_RREAD,
        S_RCHK2,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_dp_op  op;
        t_status res;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic size_ok;
        logic cls_free_zero;
        logic scan_hit;
        logic scan_last;
        logic p_over;
        logic k_full;
        logic cnt_nz;
        logic cnt_full;
        logic k_eq_cnt;
        logic walk_eq_idx;
        logic free_pg_bad;
        logic free_fmt_bad;
        logic fill_last;
        logic whole_over;
    } t_dp_stat;

    typedef struct packed {
        logic [2:0]        cls;
        logic [SLOT_W-1:0] cnt;
        logic [7:0]        head;
        logic [PW-1:0]     nxt;
    } t_page;

    function automatic logic [SLOT_W-1:0] per_page(input logic [2:0] c);
        return SLOT_W'((PAGE_BYTES >> (int'(c) + MIN_SHIFT)) - 1);
    endfunction

    function automatic logic [2:0] size_class(input logic [15:0] sz);
        logic [2:0] c;
        c = 3'd6;
        for (int j = 5; j >= 0; j--) begin
            if (sz <= (16'd32 << j)) begin
                c = 3'(j);
            end
        end
        return c;
    endfunction

    function automatic logic size_ok(input logic [15:0] sz);
        return (sz != 16'd0) && (sz <= 16'(MAX_REQUEST));
    endfunction

endpackage

// File: hw/rtl/size_class_superblock_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// size_class_superblock_allocator
// power-of-two size class allocator over a fixed pool of superblock pages
// ---------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  request  in         i_in_valid / o_in_ready    opcode, size, free address
//  result   out        o_out_valid / i_out_ready  status, address, release
//  config   in         i_cfg_we                   reserve threshold
//
//  one request at a time; each superblock list hop reads the page memory (S_WREAD, S_WCHK)
//  alloc from a fresh page adds a pool scan over up to 64 pages, then writes each object's link
//  free checks each free-list entry (S_DUP, S_DUP2), then walks release hops (S_RREAD, S_RCHK2)
//  synchronous active-low reset; no clearing pass, memories need none
//  a result held by a stalled consumer does not block the next request
// ---------------------------------------------------------------------------
`include "size_class_superblock_allocator_assert.svh"

module size_class_superblock_allocator import sca_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_request_size,
    input  logic [17:0] i_free_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [17:0] o_object_address,
    output logic        o_page_released,
    output logic [5:0]  o_released_page,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sca_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_opcode         (i_opcode),
        .i_request_size   (i_request_size),
        .i_free_address   (i_free_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_status         (o_status),
        .o_object_address (o_object_address),
        .o_page_released  (o_page_released),
        .o_released_page  (o_released_page)
    );

    `SCA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `SCA_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, cmd.op == OP_OUT_LOAD, o_out_valid)
    `SCA_ASSERT_NOW(a_fail_clean, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_object_address == 18'd0 && !o_page_released)
    `SCA_ASSERT_NOW(a_release_no_addr, i_clk, i_rst_n, o_out_valid && o_page_released, o_object_address == 18'd0)

endmodule

// File: hw/rtl/sca_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sca_dp
// allocator datapath: page and free-list memories, class counters, results
// ---------------------------------------------------------------------------
module sca_dp import sca_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_opcode,
    input  logic [15:0] i_request_size,
    input  logic [17:0] i_free_address,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic [1:0]  o_status,
    output logic [17:0] o_object_address,
    output logic        o_page_released,
    output logic [5:0]  o_released_page
);

    t_page              m_page [PAGE_COUNT];
    logic [7:0]         m_onf  [ONF_DEPTH];

    logic               r_opc;
    logic               r_size_ok;
    logic [2:0]         r_cls;
    logic [17:0]        r_addr;
    logic [PW-1:0]      r_p;
    logic [PW-1:0]      r_prev;
    logic [KW-1:0]      r_k;
    logic [SLOT_W-1:0]  r_i;
    logic [SLOT_W-1:0]  r_idx;
    logic [SLOT_W-1:0]  r_walk;
    logic [6:0]         r_thr;
    logic [PAGE_COUNT-1:0] r_in_use;
    logic [PW-1:0]      r_cls_head  [CLASS_COUNT];
    logic [12:0]        r_cls_free  [CLASS_COUNT];
    logic [6:0]         r_cls_whole [CLASS_COUNT];
    t_page              r_pg_rd;
    t_page              r_prev_pg;
    logic [7:0]         r_onf_rd;
    t_status            r_res_st;
    logic [17:0]        r_res_addr;
    logic               r_res_rel;
    logic [5:0]         r_res_page;
    logic [1:0]         r_o_st;
    logic [17:0]        r_o_addr;
    logic               r_o_rel;
    logic [5:0]         r_o_page;

    logic [SLOT_W-1:0]  full;
    logic [5:0]         f_pg;
    logic [11:0]        f_off;
    logic [3:0]         f_shift;
    logic [11:0]        f_mask;
    logic [11:0]        f_idx_w;
    logic [3:0]         a_shift;
    logic [17:0]        a_addr;

    logic               pg_re;
    logic [PI-1:0]      pg_raddr;
    logic               pg_we;
    logic [PI-1:0]      pg_waddr;
    t_page              pg_wdata;
    logic               onf_re;
    logic [ONF_W-1:0]   onf_raddr;
    logic               onf_we;
    logic [ONF_W-1:0]   onf_waddr;
    logic [7:0]         onf_wdata;

    assign full    = per_page(r_cls);
    assign f_pg    = r_addr[17:12];
    assign f_off   = r_addr[11:0];
    assign f_shift = {1'b0, r_pg_rd.cls} + 4'(MIN_SHIFT);
    assign f_mask  = (12'd1 << f_shift) - 12'd1;
    assign f_idx_w = f_off >> f_shift;
    assign a_shift = {1'b0, r_cls} + 4'(MIN_SHIFT);
    assign a_addr  = {r_p[PI-1:0], 12'd0} + (18'(r_idx) << a_shift);

    // status toward the controller
    always_comb begin
        o_stat.is_free       = r_opc;
        o_stat.size_ok       = r_size_ok;
        o_stat.cls_free_zero = r_cls_free[r_cls] == 13'd0;
        o_stat.scan_hit      = !r_in_use[r_p[PI-1:0]];
        o_stat.scan_last     = r_p == PW'(PAGE_COUNT - 1);
        o_stat.p_over        = r_p >= NO_PAGE;
        o_stat.k_full        = r_k == KW'(PAGE_COUNT);
        o_stat.cnt_nz        = r_pg_rd.cnt != '0;
        o_stat.cnt_full      = r_pg_rd.cnt == full;
        o_stat.k_eq_cnt      = r_k == KW'(r_pg_rd.cnt);
        o_stat.walk_eq_idx   = r_walk == r_idx;
        o_stat.free_pg_bad   = (32'(f_pg) >= PAGE_COUNT) || !r_in_use[f_pg];
        o_stat.free_fmt_bad  = (32'(r_pg_rd.cls) >= CLASS_COUNT) ||
                               ((f_off & f_mask) != 12'd0) || (f_idx_w == 12'd0);
        o_stat.fill_last     = r_i == full;
        o_stat.whole_over    = r_cls_whole[r_cls] > r_thr;
    end

    // memory port selection
    always_comb begin
        pg_re     = (i_cmd.op == OP_READ_P) || (i_cmd.op == OP_FREE_READ);
        pg_raddr  = (i_cmd.op == OP_FREE_READ) ? f_pg : r_p[PI-1:0];
        onf_re    = (i_cmd.op == OP_TAKE) || (i_cmd.op == OP_DUP_READ);
        onf_raddr = (i_cmd.op == OP_TAKE) ? {r_p[PI-1:0], r_pg_rd.head[SLOT_W-1:0]}
                                          : {r_p[PI-1:0], r_walk};
        pg_we     = 1'b0;
        pg_waddr  = r_p[PI-1:0];
        pg_wdata  = r_pg_rd;
        onf_we    = 1'b0;
        onf_waddr = {r_p[PI-1:0], r_idx};
        onf_wdata = r_pg_rd.head;
        case (i_cmd.op)
            OP_INIT: begin
                pg_we         = 1'b1;
                pg_wdata.cls  = r_cls;
                pg_wdata.cnt  = full;
                pg_wdata.head = 8'(full);
                pg_wdata.nxt  = r_cls_head[r_cls];
            end
            OP_FILL: begin
                onf_we    = 1'b1;
                onf_waddr = {r_p[PI-1:0], r_i};
                onf_wdata = 8'(r_i - SLOT_W'(1));
            end
            OP_TAKE_DONE: begin
                pg_we         = 1'b1;
                pg_wdata.cnt  = r_pg_rd.cnt - SLOT_W'(1);
                pg_wdata.head = r_onf_rd;
            end
            OP_PUSH: begin
                pg_we         = 1'b1;
                pg_wdata.cnt  = r_pg_rd.cnt + SLOT_W'(1);
                pg_wdata.head = 8'(r_idx);
                onf_we        = 1'b1;
            end
            OP_RELEASE: begin
                pg_we        = r_prev != NO_PAGE;
                pg_waddr     = r_prev[PI-1:0];
                pg_wdata     = r_prev_pg;
                pg_wdata.nxt = r_pg_rd.nxt;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            m_page[pg_waddr] <= pg_wdata;
        end
        if (pg_re) begin
            r_pg_rd <= m_page[pg_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (onf_we) begin
            m_onf[onf_waddr] <= onf_wdata;
        end
        if (onf_re) begin
            r_onf_rd <= m_onf[onf_raddr];
        end
    end

    // class state, page pool and threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= 7'd2;
            r_in_use <= '0;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_cls_head[c]  <= NO_PAGE;
                r_cls_free[c]  <= '0;
                r_cls_whole[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            case (i_cmd.op)
                OP_INIT: begin
                    r_in_use[r_p[PI-1:0]] <= 1'b1;
                    r_cls_head[r_cls]     <= r_p;
                    r_cls_whole[r_cls]    <= r_cls_whole[r_cls] + 7'd1;
                    r_cls_free[r_cls]     <= r_cls_free[r_cls] + 13'(full);
                end
                OP_TAKE_DONE: begin
                    if (r_pg_rd.cnt == full && r_cls_whole[r_cls] != 7'd0) begin
                        r_cls_whole[r_cls] <= r_cls_whole[r_cls] - 7'd1;
                    end
                    r_cls_free[r_cls] <= r_cls_free[r_cls] - 13'd1;
                end
                OP_PUSH: begin
                    r_cls_free[r_cls] <= r_cls_free[r_cls] + 13'd1;
                    if (({1'b0, r_pg_rd.cnt} + 8'd1) == {1'b0, full}) begin
                        r_cls_whole[r_cls] <= r_cls_whole[r_cls] + 7'd1;
                    end
                end
                OP_RELEASE: begin
                    if (r_prev == NO_PAGE) begin
                        r_cls_head[r_cls] <= r_pg_rd.nxt;
                    end
                    r_cls_whole[r_cls]    <= r_cls_whole[r_cls] - 7'd1;
                    r_cls_free[r_cls]     <= r_cls_free[r_cls] - 13'(full);
                    r_in_use[r_p[PI-1:0]] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers and result staging
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_opc     <= i_opcode;
                r_size_ok <= size_ok(i_request_size);
                r_cls     <= size_class(i_request_size);
                r_addr    <= i_free_address;
            end
            OP_RESULT: begin
                r_res_st   <= i_cmd.res;
                r_res_addr <= '0;
                r_res_rel  <= 1'b0;
                r_res_page <= '0;
            end
            OP_SCAN_START: r_p <= '0;
            OP_SCAN_NEXT:  r_p <= r_p + PW'(1);
            OP_INIT:       r_i <= SLOT_W'(1);
            OP_FILL: begin
                r_i <= r_i + SLOT_W'(1);
                r_k <= '0;
            end
            OP_WALK_START: begin
                r_p <= r_cls_head[r_cls];
                r_k <= '0;
            end
            OP_WALK_NEXT: begin
                r_p <= r_pg_rd.nxt;
                r_k <= r_k + KW'(1);
            end
            OP_TAKE: r_idx <= r_pg_rd.head[SLOT_W-1:0];
            OP_TAKE_DONE: begin
                r_res_st   <= ST_OK;
                r_res_addr <= a_addr;
                r_res_rel  <= 1'b0;
                r_res_page <= '0;
            end
            OP_FREE_READ: r_p <= PW'(f_pg);
            OP_FREE_SETUP: begin
                r_cls  <= r_pg_rd.cls;
                r_idx  <= f_idx_w[SLOT_W-1:0];
                r_walk <= r_pg_rd.head[SLOT_W-1:0];
                r_k    <= '0;
            end
            OP_DUP_NEXT: begin
                r_walk <= r_onf_rd[SLOT_W-1:0];
                r_k    <= r_k + KW'(1);
            end
            OP_REL_START: begin
                r_p    <= r_cls_head[r_cls];
                r_prev <= NO_PAGE;
                r_k    <= '0;
            end
            OP_REL_NEXT: begin
                r_prev    <= r_p;
                r_prev_pg <= r_pg_rd;
                r_p       <= r_pg_rd.nxt;
                r_k       <= r_k + KW'(1);
            end
            OP_RELEASE: begin
                r_res_st   <= ST_OK;
                r_res_addr <= '0;
                r_res_rel  <= 1'b1;
                r_res_page <= r_p[5:0];
            end
            OP_OUT_LOAD: begin
                r_o_st   <= r_res_st;
                r_o_addr <= r_res_addr;
                r_o_rel  <= r_res_rel;
                r_o_page <= r_res_page;
            end
            default: begin
            end
        endcase
    end

    assign o_status         = r_o_st;
    assign o_object_address = r_o_addr;
    assign o_page_released  = r_o_rel;
    assign o_released_page  = r_o_page;

endmodule

// File: hw/rtl/sca_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sca_ctrl
// allocator sequencer: request decode, list walks, pool scan, output slot
// ---------------------------------------------------------------------------
module sca_ctrl import sca_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == OP_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (i_stat.is_free) begin
                    n_state = i_stat.free_pg_bad ? S_EMIT : S_FCLS;
                end else if (!i_stat.size_ok) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = i_stat.cls_free_zero ? S_SCAN : S_WREAD;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    n_state = S_INIT;
                end else if (i_stat.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_INIT:      n_state = S_FILL;
            S_FILL:      if (i_stat.fill_last) n_state = S_WREAD;
            S_WREAD:     n_state = i_stat.p_over ? S_EMIT : S_WCHK;
            S_WCHK: begin
                if (i_stat.cnt_nz) begin
                    n_state = S_TAKE_DONE;
                end else if (i_stat.k_full) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_WREAD;
                end
            end
            S_TAKE_DONE: n_state = S_EMIT;
            S_FCLS:      n_state = i_stat.free_fmt_bad ? S_EMIT : S_DUP;
            S_DUP: begin
                if (i_stat.k_eq_cnt) begin
                    n_state = S_RCHK;
                end else if (i_stat.walk_eq_idx) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DUP2;
                end
            end
            S_DUP2:      n_state = S_DUP;
            S_RCHK:      n_state = i_stat.whole_over ? S_RREAD : S_EMIT;
            S_RREAD:     n_state = (i_stat.p_over || i_stat.k_full) ? S_EMIT : S_RCHK2;
            S_RCHK2:     n_state = i_stat.cnt_full ? S_EMIT : S_RREAD;
            S_EMIT:      if (slot_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op  = OP_IDLE;
        o_cmd.res = ST_OK;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LATCH;
            end
            S_DECODE: begin
                if (i_stat.is_free) begin
                    if (i_stat.free_pg_bad) begin
                        o_cmd.op  = OP_RESULT;
                        o_cmd.res = ST_BAD_FREE;
                    end else begin
                        o_cmd.op = OP_FREE_READ;
                    end
                end else if (!i_stat.size_ok) begin
                    o_cmd.op  = OP_RESULT;
                    o_cmd.res = ST_SIZE;
                end else begin
                    o_cmd.op = i_stat.cls_free_zero ? OP_SCAN_START : OP_WALK_START;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    o_cmd.op = OP_IDLE;
                end else if (i_stat.scan_last) begin
                    o_cmd.op  = OP_RESULT;
                    o_cmd.res = ST_NO_PAGE;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                end
            end
            S_INIT: o_cmd.op = OP_INIT;
            S_FILL: o_cmd.op = OP_FILL;
            S_WREAD: begin
                if (i_stat.p_over) begin
                    o_cmd.op  = OP_RESULT;
                    o_cmd.res = ST_NO_PAGE;
                end else begin
                    o_cmd.op = OP_READ_P;
                end
            end
            S_WCHK: begin
                if (i_stat.cnt_nz) begin
                    o_cmd.op = OP_TAKE;
                end else if (i_stat.k_full) begin
                    o_cmd.op  = OP_RESULT;
                    o_cmd.res = ST_NO_PAGE;
                end else begin
                    o_cmd.op = OP_WALK_NEXT;
                end
            end
            S_TAKE_DONE: o_cmd.op = OP_TAKE_DONE;
            S_FCLS: begin
                if (i_stat.free_fmt_bad) begin
                    o_cmd.op  = OP_RESULT;
                    o_cmd.res = ST_BAD_FREE;
                end else begin
                    o_cmd.op = OP_FREE_SETUP;
                end
            end
            S_DUP: begin
                if (i_stat.k_eq_cnt) begin
                    o_cmd.op = OP_PUSH;
                end else if (i_stat.walk_eq_idx) begin
                    o_cmd.op  = OP_RESULT;
                    o_cmd.res = ST_BAD_FREE;
                end else begin
                    o_cmd.op = OP_DUP_READ;
                end
            end
            S_DUP2: o_cmd.op = OP_DUP_NEXT;
            S_RCHK: begin
                if (i_stat.whole_over) begin
                    o_cmd.op = OP_REL_START;
                end else begin
                    o_cmd.op  = OP_RESULT;
                    o_cmd.res = ST_OK;
                end
            end
            S_RREAD: begin
                if (i_stat.p_over || i_stat.k_full) begin
                    o_cmd.op  = OP_RESULT;
                    o_cmd.res = ST_OK;
                end else begin
                    o_cmd.op = OP_READ_P;
                end
            end
            S_RCHK2: o_cmd.op = i_stat.cnt_full ? OP_RELEASE : OP_REL_NEXT;
            S_EMIT:  if (slot_free) o_cmd.op = OP_OUT_LOAD;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the size class superblock allocator: requests are
// predicted one by one in a behavioral model of the page pool and compared
// field by field with each result transfer, under random stalls on both sides
// ---------------------------------------------------------------------------
module testbench;
    import sca_pkg::*;

    typedef struct {
        t_status     status;
        logic [17:0] addr;
        logic        released;
        logic [5:0]  rel_page;
    } t_alloc_result;

    localparam int SLOTS = 128;
    localparam int DRAIN_CYCLES = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = 1'b0;
    logic [15:0] i_request_size = '0;
    logic [17:0] i_free_address = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [17:0] o_object_address;
    logic        o_page_released;
    logic [5:0]  o_released_page;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;

    int pg_used[PAGE_COUNT];
    int pg_cls[PAGE_COUNT];
    int pg_cnt[PAGE_COUNT];
    int pg_head[PAGE_COUNT];
    int pg_next[PAGE_COUNT];
    int obj_link[PAGE_COUNT*SLOTS];
    int cls_head[CLASS_COUNT];
    int cls_free[CLASS_COUNT];
    int cls_whole[CLASS_COUNT];
    int keep_whole;

    t_alloc_result pending_q[$];
    logic [17:0]   live_q[$];
    logic [17:0]   last_freed;
    bit            calm = 1'b0;
    int            errors = 0;

    size_class_superblock_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_request_size(i_request_size),
        .i_free_address(i_free_address),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_object_address(o_object_address),
        .o_page_released(o_page_released), .o_released_page(o_released_page),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int objs_per_page(int c);
        return (PAGE_BYTES >> (c + MIN_SHIFT)) - 1;
    endfunction

    function automatic t_alloc_result alloc_object(int sz);
        t_alloc_result r;
        int c, p, n, idx, g;
        r = '{ST_OK, '0, 1'b0, '0};
        if (sz == 0 || sz > MAX_REQUEST) begin
            r.status = ST_SIZE;
            return r;
        end
        c = 0;
        while ((32 << c) < sz) c++;
        n = objs_per_page(c);
        if (cls_free[c] == 0) begin
            p = 0;
            while (p < PAGE_COUNT && pg_used[p] != 0) p++;
            if (p == PAGE_COUNT) begin
                r.status = ST_NO_PAGE;
                return r;
            end
            pg_used[p] = 1;
            pg_cls[p] = c;
            pg_cnt[p] = n;
            pg_head[p] = 0;
            for (int i = 1; i <= n; i++) begin
                obj_link[p*SLOTS + i] = pg_head[p];
                pg_head[p] = i;
            end
            pg_next[p] = cls_head[c];
            cls_head[c] = p;
            cls_whole[c]++;
            cls_free[c] += n;
        end
        p = cls_head[c];
        for (g = 0; p < PAGE_COUNT && g < PAGE_COUNT; g++) begin
            if (pg_cnt[p] != 0) break;
            p = pg_next[p];
        end
        if (p >= PAGE_COUNT || pg_cnt[p] == 0) begin
            r.status = ST_NO_PAGE;
            return r;
        end
        idx = pg_head[p] % SLOTS;
        pg_head[p] = obj_link[p*SLOTS + idx];
        if (pg_cnt[p] == n && cls_whole[c] > 0) cls_whole[c]--;
        pg_cnt[p]--;
        cls_free[c]--;
        r.addr = 18'(p*PAGE_BYTES + (idx << (c + MIN_SHIFT)));
        live_q.push_back(r.addr);
        return r;
    endfunction

    function automatic t_alloc_result free_object(logic [17:0] a);
        t_alloc_result r;
        int p, off, c, sh, idx, walk, n, cur, prev, g;
        r = '{ST_BAD_FREE, '0, 1'b0, '0};
        p = a / PAGE_BYTES;
        off = a % PAGE_BYTES;
        if (p >= PAGE_COUNT || pg_used[p] == 0 || pg_cls[p] >= CLASS_COUNT) return r;
        c = pg_cls[p];
        sh = c + MIN_SHIFT;
        n = objs_per_page(c);
        if ((off & ((1 << sh) - 1)) != 0 || (off >> sh) == 0) return r;
        idx = off >> sh;
        walk = pg_head[p] % SLOTS;
        for (int k = 0; k < pg_cnt[p]; k++) begin
            if (walk == idx) return r;
            walk = obj_link[p*SLOTS + walk] % SLOTS;
        end
        r.status = ST_OK;
        for (int i = 0; i < live_q.size(); i++) begin
            if (live_q[i] == a) begin
                live_q.delete(i);
                break;
            end
        end
        obj_link[p*SLOTS + idx] = pg_head[p];
        pg_head[p] = idx;
        pg_cnt[p]++;
        cls_free[c]++;
        if (pg_cnt[p] == n) cls_whole[c]++;
        if (cls_whole[c] > keep_whole) begin
            prev = PAGE_COUNT;
            cur = cls_head[c];
            for (g = 0; cur < PAGE_COUNT && g < PAGE_COUNT; g++) begin
                if (pg_cnt[cur] == n) begin
                    if (prev == PAGE_COUNT) cls_head[c] = pg_next[cur];
                    else pg_next[prev] = pg_next[cur];
                    cls_whole[c]--;
                    cls_free[c] -= n;
                    pg_used[cur] = 0;
                    r.released = 1'b1;
                    r.rel_page = 6'(cur);
                    return r;
                end
                prev = cur;
                cur = pg_next[cur];
            end
        end
        return r;
    endfunction

    // one request transfer, at times with a random gap in front of it (never while calm)
    task automatic send_request(logic op, logic [15:0] sz, logic [17:0] a);
        if (!calm && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_request_size <= sz;
        i_free_address <= a;
        do @(posedge i_clk); while (!o_in_ready);
        if (op) begin
            pending_q.push_back(free_object(a));
            last_freed = a;
        end else begin
            pending_q.push_back(alloc_object(sz));
        end
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(int v);
        wait_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 7'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        keep_whole = v;
    endtask

    task automatic free_random_live();
        int i;
        logic [17:0] a;
        i = $urandom_range(live_q.size() - 1);
        a = live_q[i];
        send_request(1'b1, 16'($urandom), a);
    endtask

    task automatic test_sizes();
        send_request(1'b0, 16'd0, 18'h3FFFF);
        send_request(1'b0, 16'd1, 18'd0);
        send_request(1'b0, 16'd32, 18'd0);
        send_request(1'b0, 16'd33, 18'd0);
        for (int c = 2; c < CLASS_COUNT; c++) send_request(1'b0, 16'(32 << c), 18'd0);
        send_request(1'b0, 16'd2049, 18'd0);
        send_request(1'b0, 16'hFFFF, 18'd0);
    endtask

    task automatic test_bad_frees();
        logic [17:0] a;
        a = live_q[0];
        send_request(1'b1, 16'd0, 18'h3FFFF);
        send_request(1'b1, 16'd0, 18'(a - (a % PAGE_BYTES)));
        send_request(1'b1, 16'd0, a + 18'd1);
        send_request(1'b1, 16'd0, a);
        send_request(1'b1, 16'd0, a);
        send_request(1'b1, 16'd0, a - 18'd32);
        send_request(1'b1, 16'd0, 18'(a - 32 * ((a % PAGE_BYTES) / 32)));
    endtask

    task automatic test_pool_exhaust();
        write_threshold(64);
        for (int i = 0; i < 66; i++) send_request(1'b0, 16'd2048, 18'd0);
        send_request(1'b0, 16'd17, 18'd0);
        write_threshold(0);
        while (live_q.size() != 0) free_random_live();
        write_threshold(2);
    endtask

    task automatic test_lowered_threshold();
        write_threshold(64);
        for (int i = 0; i < 12; i++) send_request(1'b0, 16'd1024, 18'd0);
        while (live_q.size() != 0) free_random_live();
        send_request(1'b0, 16'd1000, 18'd0);
        write_threshold(1);
        free_random_live();
        write_threshold(0);
        send_request(1'b0, 16'd600, 18'd0);
        free_random_live();
    endtask

    task automatic test_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            if (i == 80) calm = 1'b1;
            if (i == 160) calm = 1'b0;
            if (i % 150 == 149) write_threshold($urandom_range(64));
            if (i % 97 == 50) wait_results();
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_request(1'b0, 16'($urandom), 18'($urandom));
            end else if (pick < 14) begin
                send_request(1'b1, 16'($urandom), 18'($urandom));
            end else if (pick < 17) begin
                send_request(1'b1, 16'($urandom), last_freed);
            end else if (live_q.size() != 0 &&
                         pick < (live_q.size() > 120 ? 70 : 45)) begin
                free_random_live();
            end else if (pick < 85) begin
                send_request(1'b0, 16'($urandom_range(256, 1)), 18'($urandom));
            end else begin
                send_request(1'b0, 16'($urandom_range(MAX_REQUEST, 1)), 18'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin
        t_alloc_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result transfer status=%0d addr=%0h",
                         $time, o_status, o_object_address);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_object_address !== e.addr) begin
                    $display("%0t: object_address expected %0h actual %0h",
                             $time, e.addr, o_object_address);
                    errors++;
                end
                if (o_page_released !== e.released) begin
                    $display("%0t: page_released expected %0d actual %0d",
                             $time, e.released, o_page_released);
                    errors++;
                end
                if (o_released_page !== e.rel_page) begin
                    $display("%0t: released_page expected %0d actual %0d",
                             $time, e.rel_page, o_released_page);
                    errors++;
                end
            end
        end
    end

    initial begin
        foreach (pg_used[p]) begin
            pg_used[p] = 0; pg_cls[p] = 0; pg_cnt[p] = 0; pg_head[p] = 0; pg_next[p] = 0;
        end
        foreach (obj_link[i]) obj_link[i] = 0;
        foreach (cls_head[c]) begin
            cls_head[c] = PAGE_COUNT; cls_free[c] = 0; cls_whole[c] = 0;
        end
        keep_whole = 2;
        last_freed = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_sizes();
        test_bad_frees();
        test_pool_exhaust();
        test_lowered_threshold();
        write_threshold(2);
        test_random(280);
        wait_results();
        if (errors == 0) begin
            $display("[size_class_superblock_allocator] OK");
        end else begin
            $display("[size_class_superblock_allocator] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[size_class_superblock_allocator] ERROR");
        $finish;
    end

endmodule
